// ===== src/jbt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jbt_pkg
// types, codes and byte classes shared by the json byte tokenizer
// ----------------------------------------------------------------------------
package jbt_pkg;

    // lexer modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_STR  = 2'd1;
    localparam logic [1:0] MODE_NUM  = 2'd2;

    // token kinds
    localparam logic [2:0] KIND_DELIM = 3'd0;
    localparam logic [2:0] KIND_STR   = 3'd1;
    localparam logic [2:0] KIND_NUM   = 3'd2;
    localparam logic [2:0] KIND_END   = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    // input beat modes
    localparam logic ITEM_DATA = 1'b0;
    localparam logic ITEM_END  = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic       mode;
        logic [7:0] byte_in;
    } in_t;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] char_out;
        logic       has_char;
        logic       token_done;
        logic       unterminated;
        logic       last;
    } res_t;

    // what one input beat produces
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
        logic [1:0] mode_next;
    } lex_t;

    function automatic logic is_ws(input logic [7:0] b);
        return b inside {8'h20, 8'h09, 8'h0A, 8'h0D};
    endfunction

    function automatic logic is_delim(input logic [7:0] b);
        return b inside {8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2C, 8'h3B, 8'h3A};
    endfunction

    function automatic logic is_num_start(input logic [7:0] b);
        return (b == CH_MINUS) || (b inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_num_cont(input logic [7:0] b);
        return is_num_start(b) || (b inside {8'h2E, 8'h65, 8'h45});
    endfunction

    function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] ch,
                                    input logic has, input logic done,
                                    input logic unterm);
        res_t r;
        r.token_kind   = kind;
        r.char_out     = has ? ch : 8'h00;
        r.has_char     = has;
        r.token_done   = done;
        r.unterminated = unterm;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/jbt_lex.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jbt_lex
// byte classification and result generation for one input beat
// ----------------------------------------------------------------------------
module jbt_lex (
    input  wire logic [1:0]  mode_q,
    input  wire jbt_pkg::in_t item,
    output jbt_pkg::lex_t     lex
);
    import jbt_pkg::*;

    logic [7:0] b;
    logic       idle_has;
    res_t       idle_res;
    logic [1:0] idle_mode;

    assign b = item.byte_in;

    // handling of a byte as a fresh token start
    always_comb
    begin
        idle_has  = 1'b0;
        idle_res  = mk_res(KIND_ERR, CH_NUL, 1'b0, 1'b1, 1'b0);
        idle_mode = MODE_IDLE;
        if (b == CH_NUL)
        begin
            idle_has = 1'b1;
        end
        else if (is_ws(b))
        begin
            idle_has = 1'b0;
        end
        else if (is_delim(b))
        begin
            idle_has = 1'b1;
            idle_res = mk_res(KIND_DELIM, b, 1'b1, 1'b1, 1'b0);
        end
        else if (b == CH_QUOTE)
        begin
            idle_mode = MODE_STR;
        end
        else if (is_num_start(b))
        begin
            idle_has  = 1'b1;
            idle_mode = MODE_NUM;
            idle_res  = mk_res(KIND_NUM, b, 1'b1, 1'b0, 1'b0);
        end
    end

    always_comb
    begin
        lex.cnt       = 2'd0;
        lex.r0        = idle_res;
        lex.r1        = mk_res(KIND_END, CH_NUL, 1'b0, 1'b1, 1'b0);
        lex.mode_next = MODE_IDLE;
        if (item.mode == ITEM_END)
        begin
            case (mode_q)
                MODE_STR:
                begin
                    lex.cnt = 2'd2;
                    lex.r0  = mk_res(KIND_STR, CH_NUL, 1'b0, 1'b1, 1'b1);
                end
                MODE_NUM:
                begin
                    lex.cnt = 2'd2;
                    lex.r0  = mk_res(KIND_NUM, CH_NUL, 1'b0, 1'b1, 1'b0);
                end
                default:
                begin
                    lex.cnt = 2'd1;
                    lex.r0  = mk_res(KIND_END, CH_NUL, 1'b0, 1'b1, 1'b0);
                end
            endcase
        end
        else
        begin
            case (mode_q)
                MODE_STR:
                begin
                    lex.cnt = 2'd1;
                    if (b == CH_QUOTE)
                    begin
                        lex.r0 = mk_res(KIND_STR, CH_NUL, 1'b0, 1'b1, 1'b0);
                    end
                    else
                    begin
                        lex.r0        = mk_res(KIND_STR, b, 1'b1, 1'b0, 1'b0);
                        lex.mode_next = MODE_STR;
                    end
                end
                MODE_NUM:
                begin
                    if (is_num_cont(b))
                    begin
                        lex.cnt       = 2'd1;
                        lex.r0        = mk_res(KIND_NUM, b, 1'b1, 1'b0, 1'b0);
                        lex.mode_next = MODE_NUM;
                    end
                    else
                    begin
                        // close the number, then treat the byte as a token start
                        lex.cnt       = idle_has ? 2'd2 : 2'd1;
                        lex.r0        = mk_res(KIND_NUM, CH_NUL, 1'b0, 1'b1, 1'b0);
                        lex.r1        = idle_res;
                        lex.mode_next = idle_mode;
                    end
                end
                default:
                begin
                    lex.cnt       = idle_has ? 2'd1 : 2'd0;
                    lex.mode_next = idle_mode;
                end
            endcase
        end
        lex.r0.last = (lex.cnt == 2'd1);
        lex.r1.last = 1'b1;
    end

endmodule
`default_nettype wire

// ===== src/json_byte_tokenizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// json_byte_tokenizer
// byte-serial json lexer: delimiters, strings, numbers, end and error tokens
// ----------------------------------------------------------------------------
// a beat is held in the input register until its last result is loaded
// throughput: one input beat per cycle while the output is not stalled; a beat
//   with two results is held longer, since the result register takes one a cycle
// beats with no result (whitespace, quotes opening a string) retire without waiting on the output
// reset: input and result registers empty, lexer mode idle
module json_byte_tokenizer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire jbt_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output jbt_pkg::res_t      out_data
);
    import jbt_pkg::*;

    // input register
    logic       in_valid_reg;
    in_t        in_item_reg;
    // second-result phase of the held beat
    logic       phase_reg;
    logic       phase_next;
    // lexer mode, updated when the held beat retires
    logic [1:0] mode_reg;
    // result register
    logic       out_valid_reg;
    logic       out_valid_next;
    res_t       out_data_reg;

    lex_t       lex;
    logic       out_free;
    logic       emit;
    logic       advance;

    jbt_lex u_lex (
        .mode_q (mode_reg),
        .item   (in_item_reg),
        .lex    (lex)
    );

    // result register can take a beat when empty or draining this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign emit     = in_valid_reg && (lex.cnt != 2'd0) && out_free;
    // held beat retires after its last result is loaded, or at once if it has none
    assign advance  = in_valid_reg &&
                      ((lex.cnt == 2'd0) ||
                       (out_free && ((lex.cnt == 2'd1) || phase_reg)));
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            phase_next = 1'b0;
        end
        else if (emit)
        begin
            phase_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            mode_reg      <= MODE_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg <= lex.mode_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
        if (emit)
        begin
            out_data_reg <= phase_reg ? lex.r1 : lex.r0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire
